// ===== rtl/fasg_pkg.sv =====
`default_nettype none

package fasg_pkg;

  // default sizes
  localparam int AxesDefault      = 4;
  localparam int IdleTicksDefault = 100;

  // fixed field widths
  localparam int MagW   = 14;
  localparam int PosW   = 32;
  localparam int StepsW = 17;
  localparam int IdleW  = 8;
  localparam int RegW   = 32;

  localparam logic [StepsW-1:0] StepsMax  = 17'h1_FFFF;
  localparam logic [IdleW-1:0]  IdleReset = 8'd200;

  // target scaling: mag * 2^27 / 1000 rounded equals
  // mag * 134217 + floor((mag * 91 + 62) / 125); the divide by 125 is a
  // reciprocal multiply, exact for the 21-bit remainder term
  localparam int                FracW      = 21;
  localparam logic [PosW-1:0]   TgtWhole   = 32'd134217;
  localparam logic [FracW-1:0]  TgtFracMul = 21'd91;
  localparam logic [FracW-1:0]  TgtRound   = 21'd62;
  localparam int                RecipW     = 43;
  localparam logic [RecipW-1:0] RecipMul   = 43'd2147484;
  localparam int                RecipShift = 28;
  localparam int                QuotW      = 15;

  // serial multiplier, one multiplier bit per cycle
  localparam int MagDiffW = 33;
  localparam int MulSteps = 32;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_HOME = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  // register map
  localparam logic [3:0] CfgSprBase = 4'd0;
  localparam logic [3:0] CfgRpsBase = 4'd4;
  localparam logic [3:0] CfgCount   = 4'd8;

  localparam logic [RegW-1:0] SprReset [4] = '{32'd417215133, 32'd417215133,
                                               32'd317083504, 32'd317083504};
  localparam logic [RegW-1:0] RpsReset [4] = '{32'd674652, 32'd674652,
                                               32'd887700, 32'd887700};

  // home positions in Q5.27: 0, 0.785, -1.5708, 0 rad
  localparam logic [PosW-1:0] HomePos [4] = '{32'h0000_0000, 32'h0647_AE14,
                                              32'hF36F_0069, 32'h0000_0000};

endpackage

`default_nettype wire

// ===== rtl/four_axis_stepper_step_generator.sv =====
// command item: per axis target load, reciprocal scale, difference,
//   32-step shift-add multiply, writeback; after the last axis the result is loaded
// tick item: one axis per cycle through the shared position adder, then the result is loaded
// home and no-op items go straight to the output state; one item in flight at a time
// next item taken from the cycle after its result is loaded; an untaken result stalls the output
// reset: positions, step counts, pins cleared, idle counters at 200, registers at defaults
`default_nettype none

module four_axis_stepper_step_generator
  import fasg_pkg::*;
#(
  parameter int AXES       = AxesDefault,
  parameter int IDLE_TICKS = IdleTicksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // target_mag_0, target_mag_1, target_mag_2, target_mag_3,
  // target_neg_0, target_neg_1, target_neg_2, target_neg_3, homed_axis, zero fill
  input  wire logic [63:0] s_axis_tdata,
  // kind
  input  wire logic [1:0]  s_axis_tuser,
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // step_levels, dir_levels, enable_levels, zero fill
  output logic [15:0]      m_axis_tdata,
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int IdxW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(AXES - 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_DIFF = 8'b0000_1000,
    ST_MUL  = 8'b0001_0000,
    ST_WB   = 8'b0010_0000,
    ST_TICK = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     idx_q;
  logic [5:0]          cnt_q;
  logic [3:0]          stepped_q;
  logic                m_valid_q;
  logic [11:0]         out_q;

  // configuration
  logic [RegW-1:0]     spr_q [4];
  logic [RegW-1:0]     rps_q [4];

  // per-axis state
  logic [PosW-1:0]     pos_q     [AXES];
  logic [StepsW-1:0]   steps_q   [AXES];
  logic                down_q    [AXES];
  logic                dir_q     [AXES];
  logic [IdleW-1:0]    idle_q    [AXES];
  logic                en_q      [AXES];

  // command item fields
  logic [MagW-1:0]     mag_in_q  [4];
  logic                neg_in_q  [4];

  // shared arithmetic unit
  logic [FracW-1:0]    frac_q;
  logic [PosW-1:0]     base_q;
  logic [PosW-1:0]     tgt_q;
  logic [MagDiffW-1:0] mag_q;
  logic                down_cmd_q;
  logic [MagDiffW-1:0] hi_q;
  logic [31:0]         lo_q;

  logic                in_accept;
  logic                out_load;
  logic [1:0]          home_axis;
  kind_e               kind;
  logic [3:0]          idx_ext;
  logic                idx_real;
  logic [RegW-1:0]     cur_spr;
  logic [RegW-1:0]     cur_rps;
  logic [MagW-1:0]     cur_mag;
  logic                cur_neg;
  logic [PosW-1:0]     cur_pos;
  logic [RecipW-1:0]   recip_prod;
  logic [33:0]         tgt_abs;
  logic [33:0]         tgt_s;
  logic [33:0]         diff;
  logic [MagDiffW-1:0] diff_mag;
  logic                diff_down;
  logic [33:0]         mul_sum;
  logic [StepsW-1:0]   steps_sat;
  logic                busy;
  logic [PosW-1:0]     delta;
  logic [PosW-1:0]     pos_next;
  logic [IdleW-1:0]    idle_next;
  logic [3:0]          dir_vec;
  logic [3:0]          en_vec;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};
  assign kind          = kind_e'(s_axis_tuser);
  assign home_axis     = s_axis_tdata[61:60];
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // operand selection for the current axis; axes past four see zero configuration and command operands
  assign idx_ext  = 4'(idx_q);
  assign idx_real = (idx_ext < 4'd4);
  assign cur_spr  = idx_real ? spr_q[idx_ext[1:0]] : '0;
  assign cur_rps  = idx_real ? rps_q[idx_ext[1:0]] : '0;
  assign cur_mag  = idx_real ? mag_in_q[idx_ext[1:0]] : '0;
  assign cur_neg  = idx_real ? neg_in_q[idx_ext[1:0]] : 1'b0;
  assign cur_pos  = pos_q[idx_q];

  // divide by 125 as a reciprocal multiply
  assign recip_prod = RecipW'(frac_q) * RecipMul;

  // signed difference position minus target
  assign tgt_abs   = {2'b00, tgt_q};
  assign tgt_s     = cur_neg ? (34'd0 - tgt_abs) : tgt_abs;
  assign diff      = {{2{cur_pos[PosW-1]}}, cur_pos} - tgt_s;
  assign diff_mag  = diff[33] ? MagDiffW'(34'd0 - diff) : diff[MagDiffW-1:0];
  assign diff_down = !diff[33] && (diff != 34'd0);

  // shift-add multiply step, product ends in {hi, lo}; steps are product >> 43
  assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mag_q} : 34'd0);
  assign steps_sat = (hi_q[32:28] != 5'd0) ? StepsMax : hi_q[27:11];

  // tick update for the current axis
  assign busy      = (steps_q[idx_q] != '0);
  assign delta     = PosW'(cur_rps[31:5]) + PosW'(cur_rps[4]);
  assign pos_next  = down_q[idx_q] ? (cur_pos - delta) : (cur_pos + delta);
  always_comb begin
    if (busy) begin
      idle_next = IdleW'(IDLE_TICKS);
    end else if (idle_q[idx_q] != '0) begin
      idle_next = idle_q[idx_q] - 8'd1;
    end else begin
      idle_next = '0;
    end
  end

  // pin levels shown in the result
  always_comb begin
    dir_vec = '0;
    en_vec  = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < AXES) begin
        dir_vec[i] = dir_q[i];
        en_vec[i]  = en_q[i];
      end
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      stepped_q <= '0;
      m_valid_q <= 1'b0;
      out_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        spr_q[i] <= SprReset[i];
        rps_q[i] <= RpsReset[i];
      end
      for (int i = 0; i < AXES; i++) begin
        pos_q[i]   <= '0;
        steps_q[i] <= '0;
        down_q[i]  <= 1'b0;
        dir_q[i]   <= 1'b0;
        idle_q[i]  <= IdleReset;
        en_q[i]    <= 1'b0;
      end
    end else begin
      // register writes, indexes past the map are dropped
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgCount)) begin
        if (cfg_index_i >= CfgRpsBase) begin
          rps_q[cfg_index_i[1:0]] <= cfg_data_i;
        end else begin
          spr_q[cfg_index_i[1:0]] <= cfg_data_i;
        end
      end

      // output register: load a new result or drop a taken one
      if (out_load) begin
        out_q     <= {en_vec, dir_vec, stepped_q};
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            idx_q     <= '0;
            stepped_q <= '0;
            case (kind)
              KIND_CMD:  state_q <= ST_LOAD;
              KIND_TICK: state_q <= ST_TICK;
              KIND_HOME: begin
                for (int i = 0; i < AXES; i++) begin
                  if (32'(home_axis) == i) begin
                    pos_q[i] <= HomePos[home_axis];
                  end
                end
                state_q <= ST_OUT;
              end
              default:   state_q <= ST_OUT;
            endcase
          end
        end
        ST_LOAD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          cnt_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(MulSteps - 1)) begin
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          steps_q[idx_q] <= steps_sat;
          down_q[idx_q]  <= down_cmd_q;
          if (idx_q == LastIdx) begin
            state_q <= ST_OUT;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= ST_LOAD;
          end
        end
        ST_TICK: begin
          idle_q[idx_q] <= idle_next;
          en_q[idx_q]   <= (idle_next == '0) && (idx_ext != 4'd2);
          if (busy) begin
            dir_q[idx_q]   <= (idx_ext < 4'd2) ? !down_q[idx_q] : down_q[idx_q];
            pos_q[idx_q]   <= pos_next;
            steps_q[idx_q] <= steps_q[idx_q] - StepsW'(1);
            if (idx_real) begin
              stepped_q[idx_ext[1:0]] <= 1'b1;
            end
          end
          if (idx_q == LastIdx) begin
            state_q <= ST_OUT;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath of the shared scale and multiply unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          for (int i = 0; i < 4; i++) begin
            mag_in_q[i] <= s_axis_tdata[i*MagW +: MagW];
            neg_in_q[i] <= s_axis_tdata[4*MagW + i];
          end
        end
      end
      ST_LOAD: begin
        frac_q <= FracW'(cur_mag) * TgtFracMul + TgtRound;
        base_q <= PosW'(cur_mag) * TgtWhole;
      end
      ST_DIV: begin
        tgt_q <= base_q + PosW'(recip_prod[RecipShift +: QuotW]);
      end
      ST_DIFF: begin
        mag_q      <= diff_mag;
        down_cmd_q <= diff_down;
        hi_q       <= '0;
        lo_q       <= cur_spr;
      end
      ST_MUL: begin
        hi_q <= mul_sum[33:1];
        lo_q <= {mul_sum[0], lo_q[31:1]};
      end
      default: ;
    endcase
  end

  // one item in flight: an accepted item drops ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("ready stayed high after an item was accepted");

  // axis 2 enable pin never goes high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[10])
    else $error("axis 2 enable driven high");

  // a command never reports step pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |-> (stepped_q == 4'd0))
    else $error("step pulses recorded during a command");

  // the multiplier count stays inside its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (cnt_q < 6'(MulSteps)))
    else $error("multiplier step count out of range");

endmodule

`default_nettype wire
